### design/ssn_pkg.sv
// Shared constants and codes for the sensor subscription notifier.
`timescale 1ns / 1ps
`default_nettype none
package ssn_pkg;

	localparam int SLOTS_DEF      = 8;
	localparam int SENSORS_DEF    = 4;
	localparam int NOTIFY_IDS_DEF = 8;

	localparam logic [7:0] RX_SENS1_LO = 8'h61; // 'a'
	localparam logic [7:0] RX_SENS1_HI = 8'h62; // 'b'
	localparam logic [7:0] RX_SENS2_LO = 8'h63; // 'c'
	localparam logic [7:0] RX_SENS2_HI = 8'h64; // 'd'

	localparam logic MODE_SUB  = 1'b0;
	localparam logic MODE_TICK = 1'b1;

	localparam logic [1:0] KIND_SUB    = 2'd0;
	localparam logic [1:0] KIND_NOTIFY = 2'd1;
	localparam logic [1:0] KIND_DONE   = 2'd2;

	localparam logic [1:0] STAT_ADDED  = 2'd0;
	localparam logic [1:0] STAT_DUP    = 2'd1;
	localparam logic [1:0] STAT_FULL   = 2'd2;
	localparam logic [1:0] STAT_REJECT = 2'd3;

	typedef struct packed {
		logic [2:0] sem;
		logic [1:0] sensor;
		logic [7:0] state;
	} entry_t;

endpackage
`default_nettype wire

### design/sensor_subscription_notifier.sv
// Sensor subscription notifier: one-shot subscription table with tick-driven scan.
`timescale 1ns / 1ps
`default_nettype none
// One item is taken at a time. Subscriptions sit in a SLOTS-deep memory with
// one registered read port, and a per-slot valid flop marks occupied slots,
// which reset clears at once. Every item that is not rejected scans the memory
// one slot per cycle, pausing while a notification waits at the output. A
// duplicate ends the scan early. A tick leaves the scan to present each
// notification and then re-reads from the next slot. Every result is held in
// an output register until its transfer. A subscribe with a zero or
// out-of-range semaphore id, or an out-of-range sensor id, is rejected
// without a scan.
module sensor_subscription_notifier #(
	parameter int SLOTS      = ssn_pkg::SLOTS_DEF,
	parameter int SENSORS    = ssn_pkg::SENSORS_DEF,
	parameter int NOTIFY_IDS = ssn_pkg::NOTIFY_IDS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire        mode,
	input  wire  [2:0] sub_sem_id,
	input  wire  [1:0] sub_sensor_id,
	input  wire  [7:0] sub_state,
	input  wire        rx_valid,
	input  wire  [7:0] rx_byte,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [1:0] kind,
	output logic [1:0] status,
	output logic [2:0] slot,
	output logic [2:0] notified_sem,
	output logic       last
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int SW = $clog2(SENSORS);
	localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_OUT  = 3'b100
	} state_t;

	state_t state_q;

	ssn_pkg::entry_t mem [SLOTS];
	ssn_pkg::entry_t rd_data_s1;
	logic [SLOTS-1:0] valid_q;
	logic [SENSORS-1:0] sens_q;

	logic       mode_q;
	logic [2:0] sub_sem_q;
	logic [1:0] sub_sen_q;
	logic [7:0] sub_state_q;

	logic [CW-1:0] rd_idx_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          ff_found_q;
	logic [IW-1:0] ff_idx_q;

	logic [1:0] kind_q;
	logic [1:0] status_q;
	logic [2:0] slot_q;
	logic [2:0] nsem_q;
	logic       last_q;

	logic          in_acc;
	logic          reject;
	logic          ent_v;
	logic          sens_val;
	logic          mismatch;
	logic          match;
	logic          proc;
	logic          fire;
	logic          dup;
	logic          drained;
	logic          rd_en;
	logic          wr_en;
	logic [CW-1:0] idx_next;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	assign kind         = kind_q;
	assign status       = status_q;
	assign slot         = slot_q;
	assign notified_sem = nsem_q;
	assign last         = last_q;

	assign reject = (sub_sem_id == 3'd0) || (32'(sub_sem_id) >= NOTIFY_IDS) ||
		(32'(sub_sensor_id) >= SENSORS);

	always_comb begin
		ent_v = valid_q[idx_s1];
		if (32'(rd_data_s1.sensor) < SENSORS) begin
			sens_val = sens_q[SW'(rd_data_s1.sensor)];
		end else begin
			sens_val = 1'b0;
		end
		mismatch = (rd_data_s1.state != {7'd0, sens_val});
		match    = (rd_data_s1.sem == sub_sem_q) && (rd_data_s1.sensor == sub_sen_q) &&
			(rd_data_s1.state == sub_state_q);
		proc     = (state_q == ST_SCAN) && vld_s1;
		fire     = proc && (mode_q == ssn_pkg::MODE_TICK) && ent_v && mismatch;
		dup      = proc && (mode_q == ssn_pkg::MODE_SUB) && ent_v && match;
		drained  = (state_q == ST_SCAN) && !vld_s1 && (rd_idx_q == SLOTS_C);
		rd_en    = (state_q == ST_SCAN) && !fire && !dup && (rd_idx_q != SLOTS_C);
		wr_en    = drained && (mode_q == ssn_pkg::MODE_SUB) && ff_found_q;
		idx_next = CW'(idx_s1) + CW'(1);
	end

	// Slot memory: one read port, data registered
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_s1 <= mem[rd_idx_q[IW-1:0]];
		end
		if (wr_en) begin
			mem[ff_idx_q] <= '{sem: sub_sem_q, sensor: sub_sen_q, state: sub_state_q};
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q      <= mode;
			sub_sem_q   <= sub_sem_id;
			sub_sen_q   <= sub_sensor_id;
			sub_state_q <= sub_state;
		end
		if (rd_en) begin
			idx_s1 <= rd_idx_q[IW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			sens_q     <= '0;
			rd_idx_q   <= '0;
			vld_s1     <= 1'b0;
			ff_found_q <= 1'b0;
			ff_idx_q   <= '0;
			kind_q     <= '0;
			status_q   <= '0;
			slot_q     <= '0;
			nsem_q     <= '0;
			last_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						rd_idx_q   <= '0;
						vld_s1     <= 1'b0;
						ff_found_q <= 1'b0;
						if (mode == ssn_pkg::MODE_TICK) begin
							if (rx_valid) begin
								case (rx_byte)
									ssn_pkg::RX_SENS1_LO: sens_q[1] <= 1'b0;
									ssn_pkg::RX_SENS1_HI: sens_q[1] <= 1'b1;
									ssn_pkg::RX_SENS2_LO: sens_q[2] <= 1'b0;
									ssn_pkg::RX_SENS2_HI: sens_q[2] <= 1'b1;
									default: ;
								endcase
							end
							state_q <= ST_SCAN;
						end else if (reject) begin
							kind_q   <= ssn_pkg::KIND_SUB;
							status_q <= ssn_pkg::STAT_REJECT;
							slot_q   <= '0;
							nsem_q   <= '0;
							last_q   <= 1'b1;
							state_q  <= ST_OUT;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					vld_s1 <= rd_en;
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (proc && (mode_q == ssn_pkg::MODE_SUB) && !ent_v && !ff_found_q) begin
						ff_found_q <= 1'b1;
						ff_idx_q   <= idx_s1;
					end
					if (fire) begin
						// one-shot: free the slot, resume the scan after the transfer
						valid_q[idx_s1] <= 1'b0;
						rd_idx_q <= idx_next;
						kind_q   <= ssn_pkg::KIND_NOTIFY;
						status_q <= ssn_pkg::STAT_ADDED;
						slot_q   <= 3'(idx_s1);
						nsem_q   <= rd_data_s1.sem;
						last_q   <= 1'b0;
						state_q  <= ST_OUT;
					end else if (dup) begin
						kind_q   <= ssn_pkg::KIND_SUB;
						status_q <= ssn_pkg::STAT_DUP;
						slot_q   <= '0;
						nsem_q   <= '0;
						last_q   <= 1'b1;
						state_q  <= ST_OUT;
					end else if (drained) begin
						nsem_q  <= '0;
						last_q  <= 1'b1;
						state_q <= ST_OUT;
						if (mode_q == ssn_pkg::MODE_TICK) begin
							kind_q   <= ssn_pkg::KIND_DONE;
							status_q <= ssn_pkg::STAT_ADDED;
							slot_q   <= '0;
						end else if (ff_found_q) begin
							valid_q[ff_idx_q] <= 1'b1;
							kind_q   <= ssn_pkg::KIND_SUB;
							status_q <= ssn_pkg::STAT_ADDED;
							slot_q   <= 3'(ff_idx_q);
						end else begin
							kind_q   <= ssn_pkg::KIND_SUB;
							status_q <= ssn_pkg::STAT_FULL;
							slot_q   <= '0;
						end
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						state_q <= last_q ? ST_IDLE : ST_SCAN;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
